// ----- design/cbw_pkg.sv -----
// Shared constants and width helpers for the clamped barycentric weights unit.
// No dependencies; every other file imports this package.
`default_nettype none
package cbw_pkg;

    localparam int CBW_COORD_WIDTH      = 16;
    localparam int CBW_WEIGHT_FRAC_BITS = 15;
    localparam int CBW_LIMIT_WIDTH      = 32;
    localparam int CBW_QUEUE_DEPTH      = 2;

    // Width of the Gram determinant and the numerators, with headroom for Nu.
    function automatic int cbw_num_width(input int coord_width);
        int diff_w;
        int dot_w;
        diff_w = coord_width + 1;
        dot_w  = 2 * diff_w + 2;
        return 2 * dot_w + 2;
    endfunction

    function automatic int cbw_dot_width(input int coord_width);
        return 2 * (coord_width + 1) + 2;
    endfunction

endpackage
`default_nettype wire

// ----- design/clamped_barycentric_weights_unit.sv -----
// Pipeline from the accepting edge to o_done: seven front stages, the queue memory and
// its read register, two bit-per-stage divider pipelines of WEIGHT_FRAC_BITS+1 stages,
// a sum and an output stage.
// Throughput: one item per cycle; busy stays low since the back end never stalls.
// Reset (synchronous, active low) clears the limit register to 0 and empties the
// pipeline; results are never held off, each shows on o_done for one cycle.
`default_nettype none
module clamped_barycentric_weights_unit import cbw_pkg::*; #(
    parameter int COORD_WIDTH      = CBW_COORD_WIDTH,
    parameter int WEIGHT_FRAC_BITS = CBW_WEIGHT_FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_cfg_we,
    input  wire logic [CBW_LIMIT_WIDTH-1:0]    i_cfg_wdata,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_point_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_corner_a_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_corner_a_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_corner_a_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_corner_b_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_corner_b_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_corner_b_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_corner_c_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_corner_c_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_corner_c_z,
    output logic                               o_done,
    output logic [WEIGHT_FRAC_BITS:0]          o_weight_a,
    output logic [WEIGHT_FRAC_BITS:0]          o_weight_b,
    output logic [WEIGHT_FRAC_BITS:0]          o_weight_c,
    output logic                               o_degenerate
);
    localparam int NW = cbw_num_width(COORD_WIDTH);
    localparam logic [WEIGHT_FRAC_BITS:0] ONE =
        (WEIGHT_FRAC_BITS+1)'(1) << WEIGHT_FRAC_BITS;

    logic [CBW_LIMIT_WIDTH-1:0] r_limit;
    logic                       n_accept;
    logic                       front_vld, q_full, q_vld;
    logic [4*NW:0]              front_data, q_data;
    logic signed [COORD_WIDTH-1:0] pt[3], ca[3], cb[3], cc[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    assign n_accept = start && !busy;
    assign busy     = q_full;

    assign pt[0] = i_point_x;
    assign pt[1] = i_point_y;
    assign pt[2] = i_point_z;
    assign ca[0] = i_corner_a_x;
    assign ca[1] = i_corner_a_y;
    assign ca[2] = i_corner_a_z;
    assign cb[0] = i_corner_b_x;
    assign cb[1] = i_corner_b_y;
    assign cb[2] = i_corner_b_z;
    assign cc[0] = i_corner_c_x;
    assign cc[1] = i_corner_c_y;
    assign cc[2] = i_corner_c_z;

    cbw_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (n_accept),
        .i_limit (r_limit),
        .i_pt    (pt),
        .i_ca    (ca),
        .i_cb    (cb),
        .i_cc    (cc),
        .o_valid (front_vld),
        .o_data  (front_data)
    );

    cbw_queue #(.DATA_W(4*NW+1), .DEPTH(CBW_QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_vld),
        .i_data  (front_data),
        .o_full  (q_full),
        .o_valid (q_vld),
        .o_data  (q_data)
    );

    cbw_back #(
        .COORD_WIDTH      (COORD_WIDTH),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_vld),
        .i_data       (q_data),
        .o_valid      (o_done),
        .o_weight_a   (o_weight_a),
        .o_weight_b   (o_weight_b),
        .o_weight_c   (o_weight_c),
        .o_degenerate (o_degenerate)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_vld |-> !q_full)
        else $error("beat pushed into a full queue");

    a_degenerate_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_degenerate) |->
            (o_weight_a == ONE && o_weight_b == '0 && o_weight_c == '0))
        else $error("degenerate beat with weights other than one, zero, zero");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_weight_a <= ONE && o_weight_b <= ONE && o_weight_c <= ONE))
        else $error("weight above one");

    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((WEIGHT_FRAC_BITS+3)'(o_weight_a) + (WEIGHT_FRAC_BITS+3)'(o_weight_b)
            + (WEIGHT_FRAC_BITS+3)'(o_weight_c) <= (WEIGHT_FRAC_BITS+3)'(ONE)))
        else $error("normalized weights sum above one");

endmodule
`default_nettype wire

// ----- design/cbw_front.sv -----
// Front end: edge vectors, dot products, Gram determinant, numerators and
// degenerate classification in a seven-stage pipeline. Uses cbw_pkg.
`default_nettype none
module cbw_front import cbw_pkg::*; #(
    parameter int COORD_WIDTH = CBW_COORD_WIDTH,
    localparam int NW = cbw_num_width(COORD_WIDTH)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [CBW_LIMIT_WIDTH-1:0]    i_limit,
    input  wire logic signed [COORD_WIDTH-1:0] i_pt[3],
    input  wire logic signed [COORD_WIDTH-1:0] i_ca[3],
    input  wire logic signed [COORD_WIDTH-1:0] i_cb[3],
    input  wire logic signed [COORD_WIDTH-1:0] i_cc[3],
    output logic                               o_valid,
    output logic [4*NW:0]                      o_data
);
    localparam int DW   = COORD_WIDTH + 1;
    localparam int PW   = 2 * DW;
    localparam int DOTW = cbw_dot_width(COORD_WIDTH);
    localparam int MW   = 2 * DOTW;
    localparam int HW   = DOTW / 2;
    localparam int PPW  = DOTW + HW + 1;

    logic [6:0] r_vld;

    logic signed [DW-1:0]   r_e0[3], r_e1[3], r_e2[3];
    logic signed [PW-1:0]   r_p00[3], r_p01[3], r_p11[3], r_p20[3], r_p21[3];
    logic signed [DOTW-1:0] r_d00, r_d01, r_d11, r_d20, r_d21;
    // Products in the order d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20.
    logic signed [DOTW-1:0] n_ma[6], n_mb[6];
    logic signed [PPW-1:0]  r_mh[6], r_ml[6];
    logic signed [MW-1:0]   r_m[6];
    logic signed [NW-1:0]   r_den5, r_nv5, r_nw5;
    logic signed [NW-1:0]   r_den6, r_nv6, r_nw6, r_nu6;
    logic                   r_deg6;
    logic                   n_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    always_comb begin
        n_ma[0] = r_d00;
        n_mb[0] = r_d11;
        n_ma[1] = r_d01;
        n_mb[1] = r_d01;
        n_ma[2] = r_d11;
        n_mb[2] = r_d20;
        n_ma[3] = r_d01;
        n_mb[3] = r_d21;
        n_ma[4] = r_d00;
        n_mb[4] = r_d21;
        n_ma[5] = r_d01;
        n_mb[5] = r_d20;
    end

    always_comb begin
        n_deg = r_den5[NW-1]
            || ((r_den5[NW-1:CBW_LIMIT_WIDTH] == '0)
                && (r_den5[CBW_LIMIT_WIDTH-1:0] <= i_limit));
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_e0[k]  <= DW'(i_cb[k]) - DW'(i_ca[k]);
            r_e1[k]  <= DW'(i_cc[k]) - DW'(i_ca[k]);
            r_e2[k]  <= DW'(i_pt[k]) - DW'(i_ca[k]);
            r_p00[k] <= PW'(r_e0[k] * r_e0[k]);
            r_p01[k] <= PW'(r_e0[k] * r_e1[k]);
            r_p11[k] <= PW'(r_e1[k] * r_e1[k]);
            r_p20[k] <= PW'(r_e2[k] * r_e0[k]);
            r_p21[k] <= PW'(r_e2[k] * r_e1[k]);
        end
        r_d00 <= DOTW'(r_p00[0]) + DOTW'(r_p00[1]) + DOTW'(r_p00[2]);
        r_d01 <= DOTW'(r_p01[0]) + DOTW'(r_p01[1]) + DOTW'(r_p01[2]);
        r_d11 <= DOTW'(r_p11[0]) + DOTW'(r_p11[1]) + DOTW'(r_p11[2]);
        r_d20 <= DOTW'(r_p20[0]) + DOTW'(r_p20[1]) + DOTW'(r_p20[2]);
        r_d21 <= DOTW'(r_p21[0]) + DOTW'(r_p21[1]) + DOTW'(r_p21[2]);
        for (int j = 0; j < 6; j++) begin
            // Each wide product is formed from the upper and lower halves of one operand.
            r_mh[j] <= PPW'(n_ma[j] * $signed(n_mb[j][DOTW-1:HW]));
            r_ml[j] <= PPW'(n_ma[j] * $signed({1'b0, n_mb[j][HW-1:0]}));
            r_m[j]  <= (MW'(r_mh[j]) <<< HW) + MW'(r_ml[j]);
        end
        r_den5 <= NW'(r_m[0]) - NW'(r_m[1]);
        r_nv5  <= NW'(r_m[2]) - NW'(r_m[3]);
        r_nw5  <= NW'(r_m[4]) - NW'(r_m[5]);
        r_den6 <= r_den5;
        r_nv6  <= r_nv5;
        r_nw6  <= r_nw5;
        r_nu6  <= r_den5 - r_nv5 - r_nw5;
        r_deg6 <= n_deg;
    end

    assign o_valid = r_vld[6];
    assign o_data  = {r_deg6, r_den6, r_nu6, r_nv6, r_nw6};

endmodule
`default_nettype wire

// ----- design/cbw_queue.sv -----
// Short queue between the front end and the divider back end.
// Uses cbw_pkg for the default depth.
`default_nettype none
module cbw_queue import cbw_pkg::*; #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = CBW_QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] r_mem[DEPTH];
    logic [AW-1:0]     r_wptr, r_rptr;
    logic [AW:0]       r_cnt;
    logic              r_vld;
    logic [DATA_W-1:0] r_rd_data;
    logic              n_pop;

    // The back end never stalls, so an entry is read as soon as one is held.
    assign n_pop = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
            r_vld  <= 1'b0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (n_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(n_pop);
            r_vld <= n_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
        if (n_pop) begin
            r_rd_data <= r_mem[r_rptr];
        end
    end

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = r_vld;
    assign o_data  = r_rd_data;

endmodule
`default_nettype wire

// ----- design/cbw_back.sv -----
// Back end: three pipelined restoring dividers for the clamped ratios, then
// three more for the normalization by the weight sum. Uses cbw_pkg.
`default_nettype none
module cbw_back import cbw_pkg::*; #(
    parameter int COORD_WIDTH      = CBW_COORD_WIDTH,
    parameter int WEIGHT_FRAC_BITS = CBW_WEIGHT_FRAC_BITS,
    localparam int NW = cbw_num_width(COORD_WIDTH),
    localparam int F  = WEIGHT_FRAC_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [4*NW:0] i_data,
    output logic               o_valid,
    output logic [F:0]         o_weight_a,
    output logic [F:0]         o_weight_b,
    output logic [F:0]         o_weight_c,
    output logic               o_degenerate
);
    localparam int SW = F + 3;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    logic [NW-1:0] in_den;
    logic [NW-1:0] in_num[3];
    logic          in_deg;

    assign in_deg    = i_data[4*NW];
    assign in_den    = i_data[4*NW-1:3*NW];
    assign in_num[0] = i_data[3*NW-1:2*NW];
    assign in_num[1] = i_data[2*NW-1:NW];
    assign in_num[2] = i_data[NW-1:0];

    // Clamp-ratio stages 0..F.
    logic          r_cv[F+1];
    logic [NW-1:0] r_cden[F+1];
    logic          r_cdeg[F+1];
    logic [NW-1:0] r_crem[F+1][3];
    logic [F-1:0]  r_cq[F+1][3];
    logic          r_cz[F+1][3];
    logic          r_cf[F+1][3];
    logic [NW-1:0] n_crem[F+1][3];
    logic [F-1:0]  n_cq[F+1][3];
    logic          n_cz[3], n_cf[3];

    // Sum stage.
    logic          r_sv, r_sdeg;
    logic [F:0]    r_sq[3];
    logic [SW-1:0] r_ssum;
    logic [F:0]    n_q[3];

    // Normalization stages 0..F.
    logic          r_nv[F+1];
    logic          r_ndeg[F+1];
    logic [SW-1:0] r_nsum[F+1];
    logic [SW-1:0] r_nrem[F+1][3];
    logic [F:0]    r_nq[F+1][3];
    logic [SW-1:0] n_nrem[F+1][3];
    logic [F:0]    n_nq[F+1][3];

    logic          r_ov, r_odeg;
    logic [F:0]    r_ow[3];

    always_comb begin
        logic [NW:0] rem2;
        logic [SW:0] srem2;
        for (int l = 0; l < 3; l++) begin
            n_cz[l] = in_num[l][NW-1] || (in_num[l] == '0);
            n_cf[l] = !n_cz[l] && (in_num[l] >= in_den);
            n_crem[0][l] = (n_cz[l] || n_cf[l]) ? '0 : in_num[l];
            n_cq[0][l]   = '0;
            for (int i = 1; i <= F; i++) begin
                rem2 = {r_crem[i-1][l], 1'b0};
                if (rem2 >= {1'b0, r_cden[i-1]}) begin
                    rem2         = rem2 - {1'b0, r_cden[i-1]};
                    n_cq[i][l]   = {r_cq[i-1][l][F-2:0], 1'b1};
                end else begin
                    n_cq[i][l]   = {r_cq[i-1][l][F-2:0], 1'b0};
                end
                n_crem[i][l] = rem2[NW-1:0];
            end
            if (r_cz[F][l]) begin
                n_q[l] = '0;
            end else if (r_cf[F][l]) begin
                n_q[l] = ONE;
            end else begin
                n_q[l] = {1'b0, r_cq[F][l]};
            end
            // First quotient bit is the integer part of q / sum.
            if (SW'(r_sq[l]) >= r_ssum) begin
                n_nrem[0][l] = SW'(r_sq[l]) - r_ssum;
                n_nq[0][l]   = (F+1)'(1);
            end else begin
                n_nrem[0][l] = SW'(r_sq[l]);
                n_nq[0][l]   = '0;
            end
            for (int i = 1; i <= F; i++) begin
                srem2 = {r_nrem[i-1][l], 1'b0};
                if (srem2 >= {1'b0, r_nsum[i-1]}) begin
                    srem2      = srem2 - {1'b0, r_nsum[i-1]};
                    n_nq[i][l] = {r_nq[i-1][l][F-1:0], 1'b1};
                end else begin
                    n_nq[i][l] = {r_nq[i-1][l][F-1:0], 1'b0};
                end
                n_nrem[i][l] = srem2[SW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= F; i++) begin
                r_cv[i] <= 1'b0;
                r_nv[i] <= 1'b0;
            end
            r_sv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_cv[0] <= i_valid;
            r_nv[0] <= r_sv;
            for (int i = 1; i <= F; i++) begin
                r_cv[i] <= r_cv[i-1];
                r_nv[i] <= r_nv[i-1];
            end
            r_sv <= r_cv[F];
            r_ov <= r_nv[F];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cden[0] <= in_den;
        r_cdeg[0] <= in_deg;
        r_nsum[0] <= r_ssum;
        r_ndeg[0] <= r_sdeg;
        for (int i = 1; i <= F; i++) begin
            r_cden[i] <= r_cden[i-1];
            r_cdeg[i] <= r_cdeg[i-1];
            r_nsum[i] <= r_nsum[i-1];
            r_ndeg[i] <= r_ndeg[i-1];
        end
        for (int l = 0; l < 3; l++) begin
            r_cz[0][l] <= n_cz[l];
            r_cf[0][l] <= n_cf[l];
            for (int i = 1; i <= F; i++) begin
                r_cz[i][l] <= r_cz[i-1][l];
                r_cf[i][l] <= r_cf[i-1][l];
            end
            for (int i = 0; i <= F; i++) begin
                r_crem[i][l] <= n_crem[i][l];
                r_cq[i][l]   <= n_cq[i][l];
                r_nrem[i][l] <= n_nrem[i][l];
                r_nq[i][l]   <= n_nq[i][l];
            end
            r_sq[l] <= n_q[l];
        end
        r_sdeg <= r_cdeg[F];
        r_ssum <= SW'(n_q[0]) + SW'(n_q[1]) + SW'(n_q[2]);
        r_odeg <= r_ndeg[F];
        if (r_ndeg[F] || (r_nsum[F] == '0)) begin
            r_ow[0] <= ONE;
            r_ow[1] <= '0;
            r_ow[2] <= '0;
        end else begin
            r_ow[0] <= r_nq[F][0];
            r_ow[1] <= r_nq[F][1];
            r_ow[2] <= r_nq[F][2];
        end
    end

    assign o_valid      = r_ov;
    assign o_degenerate = r_odeg;
    assign o_weight_a   = r_ow[0];
    assign o_weight_b   = r_ow[1];
    assign o_weight_c   = r_ow[2];

endmodule
`default_nettype wire
